// ===== hw/rtl/rmd_pkg.sv =====
// Package for the rotation motion detector: widths, register indexes, reset values, stage types.
package rmd_pkg;

  localparam int CoordW  = 16;
  localparam int TimeW   = 32;
  localparam int RatioW  = 16;
  localparam int CountW  = 8;
  localparam int FillW   = 4;
  localparam int ProdW   = 32;
  localparam int FracW   = 12;
  localparam int InDataW = 88;
  localparam int OutDataW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam int JUDGE_FILL_DEFAULT  = 5;
  localparam int WINDOW_FILL_DEFAULT = 10;

  localparam logic [TimeW-1:0]  TIMEOUT_TICKS_RST  = 32'd1000;
  localparam logic [CountW-1:0] SPIN_THRESHOLD_RST = 8'd2;
  localparam logic [RatioW-1:0] MIN_X_RATIO_RST    = 16'd410;
  localparam logic [RatioW-1:0] MAX_X_RATIO_RST    = 16'd12288;
  localparam logic [RatioW-1:0] MIN_Y_RATIO_RST    = 16'd0;
  localparam logic [RatioW-1:0] MAX_Y_RATIO_RST    = 16'd2048;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_TICKS  = 3'd0,
    CFG_SPIN_THRESHOLD = 3'd1,
    CFG_MIN_X_RATIO    = 3'd2,
    CFG_MAX_X_RATIO    = 3'd3,
    CFG_MIN_Y_RATIO    = 3'd4,
    CFG_MAX_Y_RATIO    = 3'd5
  } cfg_index_t;

  // input register
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] h;
    logic [TimeW-1:0]  t;
    logic              force_spin;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } st_in_t;

  // after multiply and difference
  typedef struct packed {
    logic [ProdW-1:0]  lo_x;
    logic [ProdW-1:0]  hi_x;
    logic [ProdW-1:0]  lo_y;
    logic [ProdW-1:0]  hi_y;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              h_nz;
    logic [TimeW-1:0]  t;
    logic              force_spin;
  } st_mul_t;

  // after ratio compares; the clear variant assumes a zero previous centre
  typedef struct packed {
    logic             legal_keep;
    logic             legal_clear;
    logic [TimeW-1:0] t;
    logic             force_spin;
  } st_cmp_t;

endpackage

// ===== hw/rtl/rotation_motion_detector_unit.sv =====
// Rotation motion detector: four-stage pipeline from frame item to spin verdict.
//
// channel | dir | handshake          | contents
// s_*     | in  | s_tvalid/s_tready  | tdata: centre x, centre y, height, time, force flag
// m_*     | out | m_tvalid/m_tready  | tdata: spinning, qualified, count
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per cycle while the result register is empty or being taken; an accepted item passes
// the input register, multiply, ratio compare and state update into the result register.
// Track state is updated only in the last stage, so the timeout clear and the count
// see frames strictly in order. The whole pipeline advances together whenever the
// result register is empty or being taken. Reset is synchronous and clears the
// configuration to its defaults and all track state.
module rotation_motion_detector_unit #(
  parameter int JUDGE_FILL  = rmd_pkg::JUDGE_FILL_DEFAULT,
  parameter int WINDOW_FILL = rmd_pkg::WINDOW_FILL_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [15:0] center_x, [31:16] center_y, [47:32] box_height, [79:48] frame_time,
  // [80] force_spin, [87:81] zero
  input  logic [rmd_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] spinning, [1] qualified, [9:2] qualify_count, [15:10] zero
  output logic [rmd_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rmd_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int FillSumW = rmd_pkg::FillW + 1;

  // configuration
  logic [rmd_pkg::TimeW-1:0]  timeout_ticks;
  logic [rmd_pkg::CountW-1:0] spin_threshold;
  logic [rmd_pkg::RatioW-1:0] min_x_ratio;
  logic [rmd_pkg::RatioW-1:0] max_x_ratio;
  logic [rmd_pkg::RatioW-1:0] min_y_ratio;
  logic [rmd_pkg::RatioW-1:0] max_y_ratio;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= rmd_pkg::TIMEOUT_TICKS_RST;
      spin_threshold <= rmd_pkg::SPIN_THRESHOLD_RST;
      min_x_ratio    <= rmd_pkg::MIN_X_RATIO_RST;
      max_x_ratio    <= rmd_pkg::MAX_X_RATIO_RST;
      min_y_ratio    <= rmd_pkg::MIN_Y_RATIO_RST;
      max_y_ratio    <= rmd_pkg::MAX_Y_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmd_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        rmd_pkg::CFG_SPIN_THRESHOLD: spin_threshold <= cfg_data[rmd_pkg::CountW-1:0];
        rmd_pkg::CFG_MIN_X_RATIO:    min_x_ratio    <= cfg_data[rmd_pkg::RatioW-1:0];
        rmd_pkg::CFG_MAX_X_RATIO:    max_x_ratio    <= cfg_data[rmd_pkg::RatioW-1:0];
        rmd_pkg::CFG_MIN_Y_RATIO:    min_y_ratio    <= cfg_data[rmd_pkg::RatioW-1:0];
        rmd_pkg::CFG_MAX_Y_RATIO:    max_y_ratio    <= cfg_data[rmd_pkg::RatioW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic v1, v2, v3;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  // previous centre follows accepted items; a clear does not reset it, the clear variant
  // of the compare assumes a zero previous centre instead
  logic [rmd_pkg::CoordW-1:0] prev_x;
  logic [rmd_pkg::CoordW-1:0] prev_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (s_tvalid && s_tready) begin
      prev_x <= s_tdata[15:0];
      prev_y <= s_tdata[31:16];
    end
  end

  // stage 1: input register
  rmd_pkg::st_in_t s1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.cx         <= s_tdata[15:0];
      s1.cy         <= s_tdata[31:16];
      s1.h          <= s_tdata[47:32];
      s1.t          <= s_tdata[79:48];
      s1.force_spin <= s_tdata[80];
      s1.px         <= prev_x;
      s1.py         <= prev_y;
    end
  end

  // stage 2: bounds times height, absolute jumps
  rmd_pkg::st_mul_t s2, s2_next;

  always_comb begin
    s2_next.lo_x = {16'd0, min_x_ratio} * {16'd0, s1.h};
    s2_next.hi_x = {16'd0, max_x_ratio} * {16'd0, s1.h};
    s2_next.lo_y = {16'd0, min_y_ratio} * {16'd0, s1.h};
    s2_next.hi_y = {16'd0, max_y_ratio} * {16'd0, s1.h};
    s2_next.dx   = (s1.cx > s1.px) ? (s1.cx - s1.px) : (s1.px - s1.cx);
    s2_next.dy   = (s1.cy > s1.py) ? (s1.cy - s1.py) : (s1.py - s1.cy);
    s2_next.cx   = s1.cx;
    s2_next.cy   = s1.cy;
    s2_next.h_nz = (s1.h != '0);
    s2_next.t    = s1.t;
    s2_next.force_spin = s1.force_spin;
  end

  always_ff @(posedge clk) begin
    if (adv) s2 <= s2_next;
  end

  // stage 3: strict ratio compares, jump scaled to Q.12
  rmd_pkg::st_cmp_t s3, s3_next;
  logic [rmd_pkg::ProdW-1:0] sdx, sdy, scx, scy;

  always_comb begin
    sdx = {4'd0, s2.dx, 12'd0};
    sdy = {4'd0, s2.dy, 12'd0};
    scx = {4'd0, s2.cx, 12'd0};
    scy = {4'd0, s2.cy, 12'd0};
    s3_next.legal_keep  = s2.h_nz &&
                          sdx > s2.lo_x && sdx < s2.hi_x &&
                          sdy > s2.lo_y && sdy < s2.hi_y;
    s3_next.legal_clear = s2.h_nz &&
                          scx > s2.lo_x && scx < s2.hi_x &&
                          scy > s2.lo_y && scy < s2.hi_y;
    s3_next.t          = s2.t;
    s3_next.force_spin = s2.force_spin;
  end

  always_ff @(posedge clk) begin
    if (adv) s3 <= s3_next;
  end

  // stage 4: track state and result register
  logic [rmd_pkg::FillW-1:0]  window_fill, window_fill_next;
  logic [rmd_pkg::CountW-1:0] hit_count, hit_count_next;
  logic [rmd_pkg::TimeW-1:0]  last_hit_time, last_hit_time_next;
  logic                       have_hit, have_hit_next;
  logic                       spin_flag, spin_flag_next;
  logic                       hit;
  logic                       clr;
  logic [rmd_pkg::TimeW-1:0]  elapsed;
  logic [FillSumW-1:0]        fill;
  logic [rmd_pkg::CountW-1:0] count_base;

  always_comb begin
    elapsed = s3.t - last_hit_time;
    clr     = have_hit && (elapsed > timeout_ticks);
    fill    = (clr ? {FillSumW{1'b0}} : {1'b0, window_fill}) + FillSumW'(1);
    count_base = clr ? '0 : hit_count;

    hit = (fill >= FillSumW'(JUDGE_FILL)) &&
          ((clr ? s3.legal_clear : s3.legal_keep) || s3.force_spin);

    window_fill_next = (fill > FillSumW'(WINDOW_FILL)) ? rmd_pkg::FillW'(WINDOW_FILL)
                                                       : fill[rmd_pkg::FillW-1:0];
    if (hit) begin
      hit_count_next     = (count_base == '1) ? count_base : count_base + 8'd1;
      spin_flag_next     = hit_count_next > spin_threshold;
      last_hit_time_next = s3.t;
      have_hit_next      = 1'b1;
    end else begin
      hit_count_next     = count_base;
      spin_flag_next     = clr ? 1'b0 : spin_flag;
      last_hit_time_next = clr ? '0 : last_hit_time;
      have_hit_next      = clr ? 1'b0 : have_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill   <= '0;
      hit_count     <= '0;
      last_hit_time <= '0;
      have_hit      <= 1'b0;
      spin_flag     <= 1'b0;
    end else if (adv && v3) begin
      window_fill   <= window_fill_next;
      hit_count     <= hit_count_next;
      last_hit_time <= last_hit_time_next;
      have_hit      <= have_hit_next;
      spin_flag     <= spin_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3) begin
      m_tdata <= {6'd0, hit_count_next, hit, spin_flag_next};
    end
  end

endmodule
